// ===== rtl/core/muscl_minmod_face_reconstruction_macros.svh =====
// assertion macros for the face reconstruction block
`ifndef MUSCL_MINMOD_FACE_RECONSTRUCTION_MACROS_SVH
`define MUSCL_MINMOD_FACE_RECONSTRUCTION_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define MFR_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// plain invariant checked on every rising clock edge outside reset
`define MFR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

// ===== rtl/core/mfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// shared types and constants of the muscl minmod face reconstruction block
// ----------------------------------------------------------------------------
package mfr_pkg;

	localparam int FIELD_W = 48;
	localparam int FLOOR_W = 33;

	// configuration register indexes
	localparam logic CFG_LIMITER_MODE = 1'b0;
	localparam logic CFG_DIFF_FLOOR   = 1'b1;

	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 33'd4295;

	typedef struct packed {
		logic signed [FIELD_W-1:0] center_value;
		logic signed [FIELD_W-1:0] west_value;
		logic signed [FIELD_W-1:0] east_value;
		logic signed [FIELD_W-1:0] south_value;
		logic signed [FIELD_W-1:0] north_value;
	} cell_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] east_face;
		logic signed [FIELD_W-1:0] west_face;
		logic signed [FIELD_W-1:0] north_face;
		logic signed [FIELD_W-1:0] south_face;
	} faces_out_t;

	typedef struct packed {
		logic                limiter_on;
		logic [FLOOR_W-1:0]  diff_floor;
	} mfr_cfg_t;

endpackage

// ===== rtl/core/mfr_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_axis
// one axis of the reconstruction: differences, pipelined restoring divide
// for the minmod ratio, split multiply for the correction, saturated faces
// ----------------------------------------------------------------------------
module mfr_axis #(
	parameter int VALUE_WIDTH   = 48,
	parameter int FRACTION_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          limiter_on,
	input  logic [mfr_pkg::FLOOR_W-1:0]   diff_floor,
	input  logic signed [VALUE_WIDTH-1:0] center,
	input  logic signed [VALUE_WIDTH-1:0] prev,
	input  logic signed [VALUE_WIDTH-1:0] next,
	output logic                          out_valid,
	output logic signed [VALUE_WIDTH-1:0] plus_face,
	output logic signed [VALUE_WIDTH-1:0] minus_face
);
	import mfr_pkg::*;

	localparam int DW = VALUE_WIDTH + 1;               // difference magnitude width
	localparam int MW = (DW > FLOOR_W) ? DW : FLOOR_W; // raised magnitude width
	localparam int PW = FRACTION_BITS + 1;             // phi width
	localparam int HW = (DW + 1) / 2;                  // multiply split
	localparam int NQ = FRACTION_BITS;
	localparam int SW = VALUE_WIDTH + 2;

	// stage 1: differences and raised magnitudes
	logic signed [DW-1:0] fwd_d, bwd_d;
	logic [DW-1:0] fwd_m, bwd_m;
	logic [MW-1:0] fwd_r, bwd_r;
	logic v_s1, phi_one_s1, phi_zero_s1, neg_s1;
	logic [MW-1:0] fr_s1, br_s1;
	logic [DW-1:0] bmag_s1;
	logic signed [VALUE_WIDTH-1:0] c_s1;

	always_comb begin
		fwd_d = DW'(next) - DW'(center);
		bwd_d = DW'(center) - DW'(prev);
		fwd_m = fwd_d[DW-1] ? DW'(-fwd_d) : fwd_d;
		bwd_m = bwd_d[DW-1] ? DW'(-bwd_d) : bwd_d;
		fwd_r = MW'(fwd_m);
		bwd_r = MW'(bwd_m);
		if (fwd_m != '0 && fwd_r < MW'(diff_floor)) fwd_r = MW'(diff_floor);
		if (bwd_m != '0 && bwd_r < MW'(diff_floor)) bwd_r = MW'(diff_floor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		phi_zero_s1 <= !limiter_on || fwd_m == '0 || bwd_m == '0
			|| (fwd_d[DW-1] != bwd_d[DW-1]);
		phi_one_s1  <= fwd_r >= bwd_r;
		neg_s1      <= bwd_d[DW-1];
		fr_s1       <= fwd_r;
		br_s1       <= bwd_r;
		bmag_s1     <= bwd_m;
		c_s1        <= center;
	end

	// divider pipeline: one quotient bit per stage
	logic [NQ:0]       dv_v;
	logic [MW:0]       dv_r   [NQ+1];
	logic [MW-1:0]     dv_b   [NQ+1];
	logic [NQ-1:0]     dv_q   [NQ+1];
	logic              dv_one [NQ+1];
	logic              dv_zero[NQ+1];
	logic              dv_neg [NQ+1];
	logic [DW-1:0]     dv_m   [NQ+1];
	logic signed [VALUE_WIDTH-1:0] dv_c[NQ+1];

	assign dv_v[0]    = v_s1;
	assign dv_r[0]    = {1'b0, fr_s1};
	assign dv_b[0]    = br_s1;
	assign dv_q[0]    = '0;
	assign dv_one[0]  = phi_one_s1;
	assign dv_zero[0] = phi_zero_s1;
	assign dv_neg[0]  = neg_s1;
	assign dv_m[0]    = bmag_s1;
	assign dv_c[0]    = c_s1;

	for (genvar k = 0; k < NQ; k++) begin : g_div
		logic [MW+1:0] sh;
		logic          ge;
		assign sh = {dv_r[k], 1'b0};
		assign ge = sh >= {2'b00, dv_b[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_r[k+1]    <= ge ? (MW+1)'(sh - {2'b00, dv_b[k]}) : (MW+1)'(sh);
			dv_q[k+1]    <= {dv_q[k][NQ-2:0], ge};
			dv_b[k+1]    <= dv_b[k];
			dv_one[k+1]  <= dv_one[k];
			dv_zero[k+1] <= dv_zero[k];
			dv_neg[k+1]  <= dv_neg[k];
			dv_m[k+1]    <= dv_m[k];
			dv_c[k+1]    <= dv_c[k];
		end
	end

	// phi select and partial products
	logic [PW-1:0] phi;
	logic [HW-1:0] m_lo, m_hi;
	logic v_s2, neg_s2;
	logic [PW+HW-1:0] pp_lo_s2, pp_hi_s2;
	logic signed [VALUE_WIDTH-1:0] c_s2;

	always_comb begin
		if (dv_zero[NQ]) phi = '0;
		else if (dv_one[NQ]) phi = PW'(1) << FRACTION_BITS;
		else phi = PW'(dv_q[NQ]);
		m_lo = dv_m[NQ][HW-1:0];
		m_hi = HW'(dv_m[NQ] >> HW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= dv_v[NQ];
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s2 <= (PW+HW)'(phi) * (PW+HW)'(m_lo);
		pp_hi_s2 <= (PW+HW)'(phi) * (PW+HW)'(m_hi);
		neg_s2   <= dv_neg[NQ];
		c_s2     <= dv_c[NQ];
	end

	// combine products, shift and round toward minus infinity
	localparam int FW = PW + DW;
	logic [FW-1:0] prod;
	logic [FW-1:0] lowmask;
	logic [DW-1:0] corr;
	logic v_s3, neg_s3;
	logic [DW-1:0] corr_s3;
	logic signed [VALUE_WIDTH-1:0] c_s3;

	always_comb begin
		prod    = FW'(pp_lo_s2) + (FW'(pp_hi_s2) << HW);
		lowmask = (FW'(1) << (FRACTION_BITS + 1)) - FW'(1);
		corr    = DW'(prod >> (FRACTION_BITS + 1));
		if (neg_s2 && (prod & lowmask) != '0) corr = corr + DW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		corr_s3 <= corr;
		neg_s3  <= neg_s2;
		c_s3    <= c_s2;
	end

	// saturated faces
	localparam logic signed [SW-1:0] MAXV = SW'((SW'(1) << (VALUE_WIDTH - 1)) - SW'(1));
	localparam logic signed [SW-1:0] MINV = -SW'(SW'(1) << (VALUE_WIDTH - 1));
	logic signed [SW-1:0] cx, sc, sum_p, sum_m;
	logic signed [VALUE_WIDTH-1:0] pf, mf;

	always_comb begin
		cx    = SW'(c_s3);
		sc    = neg_s3 ? -SW'({1'b0, corr_s3}) : SW'({1'b0, corr_s3});
		sum_p = cx + sc;
		sum_m = cx - sc;
		pf = (sum_p > MAXV) ? MAXV[VALUE_WIDTH-1:0]
			: (sum_p < MINV) ? MINV[VALUE_WIDTH-1:0] : sum_p[VALUE_WIDTH-1:0];
		mf = (sum_m > MAXV) ? MAXV[VALUE_WIDTH-1:0]
			: (sum_m < MINV) ? MINV[VALUE_WIDTH-1:0] : sum_m[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		plus_face  <= pf;
		minus_face <= mf;
	end

endmodule

// ===== rtl/core/muscl_minmod_face_reconstruction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// muscl_minmod_face_reconstruction
// muscl face values of one cell with a minmod limited slope per axis
// ----------------------------------------------------------------------------
// channel   signals                         transfer
// input     start, busy, stencil            start && !busy
// output    done, faces                     done, one cycle
// config    cfg_valid, cfg_ready, cfg_*     cfg_valid && cfg_ready
//
// a cell enters every cycle; busy stays low
// faces are registered after the difference stage, the one-bit-per-stage
// divider stages, the product stage and the combine stage
// reset clears valid bits and loads the register defaults
// the receiver cannot stall, so no stage ever holds
module muscl_minmod_face_reconstruction #(
	parameter int FRACTION_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mfr_pkg::cell_in_t   stencil,
	output logic                done,
	output mfr_pkg::faces_out_t faces,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [mfr_pkg::FLOOR_W-1:0] cfg_data
);
	import mfr_pkg::*;

	localparam int VALUE_WIDTH = FIELD_W;

	mfr_cfg_t cfg_q;
	logic vx, vy;
	logic signed [VALUE_WIDTH-1:0] ef, wf, nf, sf;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration register transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limiter_on <= 1'b1;
			cfg_q.diff_floor <= FLOOR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LIMITER_MODE: cfg_q.limiter_on <= cfg_data[0];
				CFG_DIFF_FLOOR:   cfg_q.diff_floor <= cfg_data;
				default: ;
			endcase
		end
	end

	mfr_axis #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_x (
		.clk, .arst_n, .in_valid(start), .limiter_on(cfg_q.limiter_on),
		.diff_floor(cfg_q.diff_floor),
		.center(VALUE_WIDTH'(stencil.center_value)),
		.prev(VALUE_WIDTH'(stencil.west_value)),
		.next(VALUE_WIDTH'(stencil.east_value)),
		.out_valid(vx), .plus_face(ef), .minus_face(wf)
	);

	mfr_axis #(.VALUE_WIDTH(VALUE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_y (
		.clk, .arst_n, .in_valid(start), .limiter_on(cfg_q.limiter_on),
		.diff_floor(cfg_q.diff_floor),
		.center(VALUE_WIDTH'(stencil.center_value)),
		.prev(VALUE_WIDTH'(stencil.south_value)),
		.next(VALUE_WIDTH'(stencil.north_value)),
		.out_valid(vy), .plus_face(nf), .minus_face(sf)
	);

	// both axes run in lockstep
	assign done = vx & vy;
	assign faces.east_face  = FIELD_W'(ef);
	assign faces.west_face  = FIELD_W'(wf);
	assign faces.north_face = FIELD_W'(nf);
	assign faces.south_face = FIELD_W'(sf);

endmodule

// ===== rtl/core/mfr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_checker
// port level checks of the face reconstruction block
// ----------------------------------------------------------------------------
`include "muscl_minmod_face_reconstruction_macros.svh"

module mfr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_ready,
	input mfr_pkg::faces_out_t faces
);
	import mfr_pkg::*;

	// no result without an earlier transfer
	`MFR_ASSERT_IMPLY(a_done_src, clk, arst_n, done, $past(start, 36), "result without input")
	// every transfer yields a result
	`MFR_ASSERT_IMPLY(a_start_done, clk, arst_n, start && !busy, ##36 done, "lost result")
	// pipeline never stalls the sender
	`MFR_ASSERT_ALWAYS(a_no_busy, clk, arst_n, !busy && cfg_ready, "block stalled")
	// delivered faces carry no unknown bits
	`MFR_ASSERT_IMPLY(a_faces_known, clk, arst_n, done, !$isunknown(faces), "unknown faces")

endmodule

bind muscl_minmod_face_reconstruction mfr_checker u_mfr_checker (
	.clk, .arst_n, .start, .busy, .done, .cfg_ready, .faces
);
